// File: src/nqm_pkg.sv
// Shared constants for the normalized quaternion multiplier.
// No dependencies; used by nqm_unit and normalized_quaternion_multiply.
package nqm_pkg;

	// Default component width (Q2.14 when 16).
	localparam int DEF_COMPONENT_WIDTH = 16;

	// Fraction bits of a unit component (Q1.30).
	localparam int UNIT_BITS = 30;

	// Signed unit component width.
	localparam int U_W = 33;

	// Normalized sum-of-squares width, integer root width, dividend width.
	localparam int VAL_W  = 63;
	localparam int ROOT_W = 32;
	localparam int NUM_W  = 62;

	// Width of a magnitude after the normalizing shift.
	localparam int MK_W = 32;

	// Stages from input register to unit component register.
	localparam int UNIT_LAT = 76;

endpackage

// File: src/normalized_quaternion_multiply.sv
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// The square root and the dividers resolve one bit per stage, which sets the depth.
// Reset clears only the stage valid bits; data registers are not reset.
// Top level of the normalized Hamilton quaternion product; depends on nqm_pkg and nqm_unit.
module normalized_quaternion_multiply #(
	parameter int COMPONENT_WIDTH = nqm_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COMPONENT_WIDTH-1:0] a_w,
	input  logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] b_w,
	input  logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] b_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COMPONENT_WIDTH-1:0] r_w,
	output logic signed [COMPONENT_WIDTH-1:0] r_x,
	output logic signed [COMPONENT_WIDTH-1:0] r_y,
	output logic signed [COMPONENT_WIDTH-1:0] r_z,
	output logic                              degenerate
);

	localparam int W      = COMPONENT_WIDTH;
	localparam int UW     = nqm_pkg::U_W;
	localparam int PW     = 2 * UW;
	localparam int STAGES = nqm_pkg::UNIT_LAT + 5;
	localparam int SH     = 2 * nqm_pkg::UNIT_BITS - (W - 2);
	localparam logic [PW+2:0] HALF = (PW+3)'(1) << (SH - 1);
	localparam logic [PW+2:0] LO   = (PW+3)'(1) << (W - 1);
	localparam logic [PW+2:0] HI   = LO - (PW+3)'(1);

	// Stall control: every stage advances unless the output word is held.
	logic              en;
	logic [STAGES:1]   vld_q;
	assign en       = !vld_q[STAGES] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-1:1], in_valid};
		end
	end

	// Unit scaling of both inputs.
	logic signed [W-1:0]  ca [4];
	logic signed [W-1:0]  cb [4];
	logic signed [UW-1:0] ua [4];
	logic signed [UW-1:0] ub [4];
	logic                 za;
	logic                 zb;

	assign ca[0] = a_w;
	assign ca[1] = a_x;
	assign ca[2] = a_y;
	assign ca[3] = a_z;
	assign cb[0] = b_w;
	assign cb[1] = b_x;
	assign cb[2] = b_y;
	assign cb[3] = b_z;

	nqm_unit #(.W(W)) u_unit_a (
		.clk  (clk),
		.en   (en),
		.c    (ca),
		.u    (ua),
		.zero (za)
	);

	nqm_unit #(.W(W)) u_unit_b (
		.clk  (clk),
		.en   (en),
		.c    (cb),
		.u    (ub),
		.zero (zb)
	);

	// Stage 77: all sixteen component products.
	logic signed [PW-1:0] pr_s77 [4][4];
	logic                 dg_s77;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					pr_s77[i][j] <= PW'(ua[i]) * PW'(ub[j]);
				end
			end
			dg_s77 <= za || zb;
		end
	end

	// Stage 78: Hamilton terms summed in pairs.
	logic signed [PW:0] ha_s78 [4];
	logic signed [PW:0] hb_s78 [4];
	logic               dg_s78;
	always_ff @(posedge clk) begin
		if (en) begin
			ha_s78[0] <= (PW+1)'(pr_s77[0][0]) - (PW+1)'(pr_s77[1][1]);
			hb_s78[0] <= (PW+1)'(pr_s77[2][2]) + (PW+1)'(pr_s77[3][3]);
			ha_s78[1] <= (PW+1)'(pr_s77[0][1]) + (PW+1)'(pr_s77[1][0]);
			hb_s78[1] <= (PW+1)'(pr_s77[2][3]) - (PW+1)'(pr_s77[3][2]);
			ha_s78[2] <= (PW+1)'(pr_s77[0][2]) + (PW+1)'(pr_s77[2][0]);
			hb_s78[2] <= (PW+1)'(pr_s77[3][1]) - (PW+1)'(pr_s77[1][3]);
			ha_s78[3] <= (PW+1)'(pr_s77[0][3]) + (PW+1)'(pr_s77[3][0]);
			hb_s78[3] <= (PW+1)'(pr_s77[1][2]) - (PW+1)'(pr_s77[2][1]);
			dg_s78    <= dg_s77;
		end
	end

	// Stage 79: full Hamilton sums in Q2.60.
	logic signed [PW+1:0] h_s79 [4];
	logic                 dg_s79;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s79[0] <= (PW+2)'(ha_s78[0]) - (PW+2)'(hb_s78[0]);
			for (int n = 1; n < 4; n++) begin
				h_s79[n] <= (PW+2)'(ha_s78[n]) + (PW+2)'(hb_s78[n]);
			end
			dg_s79 <= dg_s78;
		end
	end

	// Stage 80: sign and magnitude.
	logic [PW+1:0] mag_s80 [4];
	logic [3:0]    ng_s80;
	logic          dg_s80;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				ng_s80[n]  <= h_s79[n][PW+1];
				mag_s80[n] <= h_s79[n][PW+1] ? $unsigned(-h_s79[n]) : $unsigned(h_s79[n]);
			end
			dg_s80 <= dg_s79;
		end
	end

	// Round half away from zero, then saturate to the component range.
	logic [PW+2:0] qv  [4];
	logic [W-1:0]  res [4];
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			qv[n] = ({1'b0, mag_s80[n]} + HALF) >> SH;
			if (ng_s80[n]) begin
				res[n] = (qv[n] > LO) ? W'(LO) : W'((PW+3)'(0) - qv[n]);
			end else begin
				res[n] = (qv[n] > HI) ? W'(HI) : W'(qv[n]);
			end
		end
	end

	// Stage 81: output word.
	logic [W-1:0] r_s81 [4];
	logic         dg_s81;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				r_s81[n] <= dg_s80 ? '0 : res[n];
			end
			dg_s81 <= dg_s80;
		end
	end

	assign r_w        = $signed(r_s81[0]);
	assign r_x        = $signed(r_s81[1]);
	assign r_y        = $signed(r_s81[2]);
	assign r_z        = $signed(r_s81[3]);
	assign degenerate = dg_s81;

endmodule

// File: src/nqm_unit.sv
// Pipelined scaling of one quaternion to unit length (Q1.30 components).
// Squares, sum, normalizing shift, bit-serial root and four dividers.
// Depends on nqm_pkg.
module nqm_unit #(
	parameter int W = nqm_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [W-1:0]               c [4],
	output logic signed [nqm_pkg::U_W-1:0]    u [4],
	output logic                              zero
);

	localparam int SQ_W  = 2 * W - 1;
	localparam int PS_W  = 2 * W;
	localparam int S_W   = 2 * W + 1;
	localparam int EX_W  = S_W + nqm_pkg::VAL_W;
	localparam int VW    = nqm_pkg::VAL_W;
	localparam int RW    = nqm_pkg::ROOT_W;
	localparam int NW    = nqm_pkg::NUM_W;
	localparam int MW    = nqm_pkg::MK_W;
	localparam int REM_W = RW + 3;

	// Stage 1: magnitudes and signs.
	logic [W-1:0] mg_s1 [4];
	logic [3:0]   neg_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s1[i] <= c[i][W-1];
				mg_s1[i]  <= c[i][W-1] ? ($unsigned(~c[i]) + 1'b1) : $unsigned(c[i]);
			end
		end
	end

	// Stage 2: squares.
	logic [SQ_W-1:0] sq_s2 [4];
	logic [W-1:0]    mg_s2 [4];
	logic [3:0]      neg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= SQ_W'(mg_s1[i]) * SQ_W'(mg_s1[i]);
			end
			mg_s2  <= mg_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: pair sums.
	logic [PS_W-1:0] sp_s3 [2];
	logic [W-1:0]    mg_s3 [4];
	logic [3:0]      neg_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sp_s3[0] <= PS_W'(sq_s2[0]) + PS_W'(sq_s2[1]);
			sp_s3[1] <= PS_W'(sq_s2[2]) + PS_W'(sq_s2[3]);
			mg_s3    <= mg_s2;
			neg_s3   <= neg_s2;
		end
	end

	// Stage 4: full sum of squares.
	logic [S_W-1:0] s_s4;
	logic [W-1:0]   mg_s4 [4];
	logic [3:0]     neg_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4   <= S_W'(sp_s3[0]) + S_W'(sp_s3[1]);
			mg_s4  <= mg_s3;
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: a sum too large for the root range is quartered instead of normalized.
	logic [EX_W-1:0] s_ext;
	logic            big_c;
	assign s_ext = EX_W'(s_s4);
	assign big_c = |s_ext[EX_W-1:VW-1];

	logic [VW-1:0] val_s5;
	logic          big_s5;
	logic          zero_s5;
	logic [MW-1:0] mk_s5 [4];
	logic [3:0]    neg_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			val_s5  <= big_c ? s_ext[VW+1:2] : {1'b0, s_ext[VW-2:0]};
			big_s5  <= big_c;
			zero_s5 <= (s_s4 == '0);
			for (int i = 0; i < 4; i++) begin
				mk_s5[i] <= MW'(mg_s4[i]);
			end
			neg_s5 <= neg_s4;
		end
	end

	// Stages 6 to 10: shift by even amounts until the sum reaches 2^60.
	// The magnitudes shift by half as much so the quotients need no shifter.
	logic [VW-1:0] nrm_val_s [6:10];
	logic [MW-1:0] nrm_mk_s  [6:10][4];
	logic          nrm_big_s [6:10];
	logic          nrm_z_s   [6:10];
	logic [3:0]    nrm_neg_s [6:10];

	for (genvar gi = 0; gi < 5; gi++) begin : g_norm
		localparam int J = 16 >> gi;
		logic [VW-1:0] v_in;
		logic [MW-1:0] m_in [4];
		logic          b_in;
		logic          z_in;
		logic [3:0]    n_in;
		logic          shf;

		if (gi == 0) begin : g_first
			assign v_in = val_s5;
			assign m_in = mk_s5;
			assign b_in = big_s5;
			assign z_in = zero_s5;
			assign n_in = neg_s5;
		end else begin : g_next
			assign v_in = nrm_val_s[5+gi];
			assign m_in = nrm_mk_s[5+gi];
			assign b_in = nrm_big_s[5+gi];
			assign z_in = nrm_z_s[5+gi];
			assign n_in = nrm_neg_s[5+gi];
		end

		assign shf = (v_in[VW-1 -: 2*J+1] == '0);

		always_ff @(posedge clk) begin
			if (en) begin
				nrm_val_s[6+gi] <= shf ? (v_in << (2 * J)) : v_in;
				for (int i = 0; i < 4; i++) begin
					nrm_mk_s[6+gi][i] <= shf ? (m_in[i] << J) : m_in[i];
				end
				nrm_big_s[6+gi] <= b_in;
				nrm_z_s[6+gi]   <= z_in;
				nrm_neg_s[6+gi] <= n_in;
			end
		end
	end

	// Stages 11 to 42: integer square root, one root bit per stage.
	logic [REM_W-1:0] sqt_rem_s  [11:42];
	logic [RW-1:0]    sqt_root_s [11:42];
	logic [VW:0]      sqt_v_s    [11:42];
	logic [MW-1:0]    sqt_mk_s   [11:42][4];
	logic             sqt_big_s  [11:42];
	logic             sqt_z_s    [11:42];
	logic [3:0]       sqt_neg_s  [11:42];

	for (genvar gi = 0; gi < RW; gi++) begin : g_sqrt
		logic [REM_W-1:0] rem_in;
		logic [RW-1:0]    root_in;
		logic [VW:0]      v_in;
		logic [MW-1:0]    m_in [4];
		logic             b_in;
		logic             z_in;
		logic [3:0]       n_in;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (gi == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = {1'b0, nrm_val_s[10]};
			assign m_in    = nrm_mk_s[10];
			assign b_in    = nrm_big_s[10];
			assign z_in    = nrm_z_s[10];
			assign n_in    = nrm_neg_s[10];
		end else begin : g_next
			assign rem_in  = sqt_rem_s[10+gi];
			assign root_in = sqt_root_s[10+gi];
			assign v_in    = sqt_v_s[10+gi];
			assign m_in    = sqt_mk_s[10+gi];
			assign b_in    = sqt_big_s[10+gi];
			assign z_in    = sqt_z_s[10+gi];
			assign n_in    = sqt_neg_s[10+gi];
		end

		assign t     = {rem_in[REM_W-3:0], v_in[VW:VW-1]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sqt_rem_s[11+gi]  <= ge ? (t - trial) : t;
				sqt_root_s[11+gi] <= {root_in[RW-2:0], ge};
				sqt_v_s[11+gi]    <= v_in << 2;
				sqt_mk_s[11+gi]   <= m_in;
				sqt_big_s[11+gi]  <= b_in;
				sqt_z_s[11+gi]    <= z_in;
				sqt_neg_s[11+gi]  <= n_in;
			end
		end
	end

	// Stage 43: dividends with half the root added for round to nearest.
	logic [NW-1:0] num_s43 [4];
	logic [RW-1:0] m_s43;
	logic          z_s43;
	logic [3:0]    neg_s43;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				num_s43[i] <= (sqt_big_s[42] ? {1'b0, sqt_mk_s[42][i], 29'b0}
					: {sqt_mk_s[42][i], 30'b0}) + NW'(sqt_root_s[42] >> 1);
			end
			m_s43   <= sqt_root_s[42];
			z_s43   <= sqt_z_s[42];
			neg_s43 <= sqt_neg_s[42];
		end
	end

	// Stages 44 to 75: four restoring dividers sharing the root as divisor.
	logic [RW-1:0] div_rem_s [44:75][4];
	logic [RW-1:0] div_lo_s  [44:75][4];
	logic [RW-1:0] div_q_s   [44:75][4];
	logic [RW-1:0] div_m_s   [44:75];
	logic          div_z_s   [44:75];
	logic [3:0]    div_neg_s [44:75];

	for (genvar gi = 0; gi < RW; gi++) begin : g_div
		logic [RW-1:0] rem_in [4];
		logic [RW-1:0] lo_in  [4];
		logic [RW-1:0] q_in   [4];
		logic [RW-1:0] m_in;
		logic          z_in;
		logic [3:0]    n_in;

		if (gi == 0) begin : g_first
			for (genvar li = 0; li < 4; li++) begin : g_lane
				assign rem_in[li] = RW'(num_s43[li][NW-1:RW]);
				assign lo_in[li]  = num_s43[li][RW-1:0];
				assign q_in[li]   = '0;
			end
			assign m_in = m_s43;
			assign z_in = z_s43;
			assign n_in = neg_s43;
		end else begin : g_next
			assign rem_in = div_rem_s[43+gi];
			assign lo_in  = div_lo_s[43+gi];
			assign q_in   = div_q_s[43+gi];
			assign m_in   = div_m_s[43+gi];
			assign z_in   = div_z_s[43+gi];
			assign n_in   = div_neg_s[43+gi];
		end

		for (genvar li = 0; li < 4; li++) begin : g_lane_step
			logic [RW:0] t;
			logic        ge;
			assign t  = {rem_in[li], lo_in[li][RW-1]};
			assign ge = (t >= {1'b0, m_in});

			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[44+gi][li] <= ge ? RW'(t - {1'b0, m_in}) : t[RW-1:0];
					div_lo_s[44+gi][li]  <= lo_in[li] << 1;
					div_q_s[44+gi][li]   <= {q_in[li][RW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_m_s[44+gi]   <= m_in;
				div_z_s[44+gi]   <= z_in;
				div_neg_s[44+gi] <= n_in;
			end
		end
	end

	// Stage 76: restore the signs.
	logic signed [nqm_pkg::U_W-1:0] u_s76 [4];
	logic                           z_s76;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				u_s76[i] <= div_neg_s[75][i] ? -$signed({1'b0, div_q_s[75][i]})
					: $signed({1'b0, div_q_s[75][i]});
			end
			z_s76 <= div_z_s[75];
		end
	end

	assign u    = u_s76;
	assign zero = z_s76;

endmodule
